@@ src/humidity_temp_frame_decoder_unit_assert.svh @@
// Assertion macros shared by the frame decoder modules.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define HTFD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package htfd_pkg;

	// CRC-8, poly 0x31, init 0xFF, no reflection, no final xor
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Byte positions inside a six-byte frame
	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	// Scaling: value = round(scale * raw / 65535) - offset
	localparam logic [14:0] TEMP_SCALE_C = 15'd17500;
	localparam logic [14:0] TEMP_SCALE_F = 15'd31500;
	localparam logic [13:0] HUM_SCALE    = 14'd10000;
	localparam logic [15:0] TEMP_OFS_C   = 16'd4500;
	localparam logic [15:0] TEMP_OFS_F   = 16'd4900;
	localparam logic [15:0] ROUND_HALF   = 16'd32767;

	// Scaled products with the rounding half already added
	typedef struct packed {
		logic        valid;
		logic        celsius;
		logic        temp_ok;
		logic        hum_ok;
		logic [30:0] temp_acc;
		logic [29:0] hum_acc;
	} htfd_acc_t;

	// One decoded result
	typedef struct packed {
		logic        humidity_valid;
		logic [13:0] humidity_centi;
		logic        temperature_valid;
		logic [15:0] temperature_centi;
	} htfd_result_t;

	// CRC-8 update over one byte, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ src/htfd_frame.sv @@
// Frame tracker: byte position, running CRC and raw words; launches the scaling
// products on the sixth byte. Depends on htfd_pkg and the assertion header.
`timescale 1ns / 1ps

module htfd_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_start,
	input  logic              celsius,
	output htfd_pkg::htfd_acc_t acc_s2
);
	import htfd_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_raw_q;
	logic [15:0] hum_raw_q;
	logic        temp_ok_q;

	logic        resync;
	logic [2:0]  eff_pos;
	logic [7:0]  crc_new;
	logic        take;
	logic        frame_done;
	logic [14:0] temp_scale;
	logic [30:0] temp_prod;
	logic [29:0] hum_prod;

	// Position and CRC after resync or a stray count
	assign resync  = in_start || (pos_q > POS_HUM_CRC);
	assign eff_pos = resync ? POS_TEMP_HI : pos_q;
	assign crc_new = crc8_byte(resync ? CRC_INIT : crc_q, in_byte);
	assign take    = en && in_valid;
	assign frame_done = take && (eff_pos == POS_HUM_CRC);

	// Position counter and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_TEMP_HI;
			crc_q <= CRC_INIT;
		end else if (take) begin
			case (eff_pos)
				POS_TEMP_CRC: begin
					crc_q <= CRC_INIT;
					pos_q <= POS_HUM_HI;
				end
				POS_HUM_CRC: begin
					crc_q <= CRC_INIT;
					pos_q <= POS_TEMP_HI;
				end
				default: begin
					crc_q <= crc_new;
					pos_q <= eff_pos + 3'd1;
				end
			endcase
		end
	end

	// Raw words and temperature check result
	always_ff @(posedge clk) begin
		if (take) begin
			case (eff_pos)
				POS_TEMP_HI:  temp_raw_q[15:8] <= in_byte;
				POS_TEMP_LO:  temp_raw_q[7:0]  <= in_byte;
				POS_TEMP_CRC: temp_ok_q        <= (crc_new == 8'h00);
				POS_HUM_HI:   hum_raw_q[15:8]  <= in_byte;
				POS_HUM_LO:   hum_raw_q[7:0]   <= in_byte;
				default:      ;
			endcase
		end
	end

	// Scaled products plus rounding half
	assign temp_scale = celsius ? TEMP_SCALE_C : TEMP_SCALE_F;
	assign temp_prod  = 31'(temp_raw_q) * 31'(temp_scale) + 31'(ROUND_HALF);
	assign hum_prod   = 30'(hum_raw_q) * 30'(HUM_SCALE) + 30'(ROUND_HALF);

	// Stage 2 register: valid follows the pipe, payload loads on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s2 <= '0;
		end else begin
			if (en) begin
				acc_s2.valid <= frame_done;
			end
			if (frame_done) begin
				acc_s2.celsius  <= celsius;
				acc_s2.temp_ok  <= temp_ok_q;
				acc_s2.hum_ok   <= (crc_new == 8'h00);
				acc_s2.temp_acc <= temp_prod;
				acc_s2.hum_acc  <= hum_prod;
			end
		end
	end

	`include "humidity_temp_frame_decoder_unit_assert.svh"

	`HTFD_ASSERT_SAME(a_pos_range, 1'b1, pos_q <= POS_HUM_CRC, "byte position out of range")
	`HTFD_ASSERT_NEXT(a_frame_wrap, frame_done, (pos_q == POS_TEMP_HI) && (crc_q == CRC_INIT),
		"frame end did not restart position and CRC")
	`HTFD_ASSERT_NEXT(a_hold_stall, !take, $stable(pos_q) && $stable(crc_q),
		"frame state moved without a beat")

endmodule

@@ src/htfd_scale.sv @@
// Scaling back end: divides the rounded products by 65535 and applies the
// offset and the CRC verdicts. Depends on htfd_pkg.
`timescale 1ns / 1ps

module htfd_scale (
	input  htfd_pkg::htfd_acc_t    acc,
	output htfd_pkg::htfd_result_t res
);
	import htfd_pkg::*;

	logic [30:0] temp_sum;
	logic [29:0] hum_sum;
	logic [15:0] temp_quot;
	logic [15:0] temp_ofs;

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 2^31
	assign temp_sum  = acc.temp_acc + 31'(acc.temp_acc[30:16]) + 31'd1;
	assign hum_sum   = acc.hum_acc + 30'(acc.hum_acc[29:16]) + 30'd1;
	assign temp_quot = 16'(temp_sum[30:16]);
	assign temp_ofs  = acc.celsius ? TEMP_OFS_C : TEMP_OFS_F;

	// A failed group reads as zero
	always_comb begin
		res.temperature_valid = acc.temp_ok;
		res.humidity_valid    = acc.hum_ok;
		res.temperature_centi = acc.temp_ok ? (temp_quot - temp_ofs) : 16'd0;
		res.humidity_centi    = acc.hum_ok ? hum_sum[29:16] : 14'd0;
	end

endmodule

@@ src/humidity_temp_frame_decoder_unit.sv @@
// Humidity / temperature frame decoder, top level.
// Uses htfd_pkg, htfd_frame, htfd_scale and the assertion header.
//
// channel  dir  beat content
// s_*      in   tdata[7:0] rx_byte, tuser frame_start
// m_*      out  tdata: temperature_centi, temperature_valid, humidity_centi,
//               humidity_valid (low bit up)
// cfg_*    in   cfg_data = celsius_mode
//
// One input beat per cycle unless the output stalls; after the sixth byte a result
// passes the input register, frame tracker with multipliers and output register.
// Reset clears position, CRC, valids and sets celsius_mode to 1.
// A stalled output register holds the whole pipe: s_tready = !m_tvalid || m_tready.
// cfg_ready is always high.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] temperature_centi, [16] temperature_valid,
	                               // [30:17] humidity_centi, [31] humidity_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import htfd_pkg::*;

	logic         en;
	logic         celsius_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	htfd_acc_t    acc_s2;
	htfd_result_t res;
	htfd_result_t result_q;

	// Whole pipe advances unless a result is stuck at the output
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			celsius_q <= 1'b1;
		end else if (cfg_valid) begin
			celsius_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	htfd_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.in_byte  (byte_s1),
		.in_start (start_s1),
		.celsius  (celsius_q),
		.acc_s2   (acc_s2)
	);

	htfd_scale u_scale (
		.acc (acc_s2),
		.res (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= acc_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && acc_s2.valid) begin
			result_q <= res;
		end
	end

	assign m_tdata = result_q;

	`include "humidity_temp_frame_decoder_unit_assert.svh"

	`HTFD_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
		"input accepted while output stalled")
	`HTFD_ASSERT_SAME(a_temp_zero, m_tvalid && !m_tdata[16], m_tdata[15:0] == 16'd0,
		"invalid temperature not zero")
	`HTFD_ASSERT_SAME(a_hum_zero, m_tvalid && !m_tdata[31], m_tdata[30:17] == 14'd0,
		"invalid humidity not zero")
	`HTFD_ASSERT_SAME(a_hum_range, m_tvalid, m_tdata[30:17] <= HUM_SCALE,
		"humidity above full scale")

endmodule
